[sv/mhpq_pkg.sv]
// Shared types and constants of the min-heap priority queue.
`timescale 1ns / 1ps

package mhpq_pkg;

  localparam int KEY_W      = 32;
  localparam int OCC_W      = 7;
  localparam int CAP_W      = 7;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // register index, taken from paddr above the byte offset
  localparam logic [CFG_ADDR_W-3:0] REG_CAPACITY = 1'b0;

  typedef enum logic {
    CMD_INSERT  = 1'b0,
    CMD_EXTRACT = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_EX_LAST,
    S_DN_RD,
    S_DN_CMP,
    S_RESP
  } state_t;

endpackage

[sv/mhpq_in_if.sv]
// Command channel of the min-heap priority queue.
`timescale 1ns / 1ps

interface mhpq_in_if;
  logic                             valid;
  logic                             ready;
  logic                             command;
  logic signed [mhpq_pkg::KEY_W-1:0] key_in;

  modport source (output valid, command, key_in, input ready);
  modport sink   (input valid, command, key_in, output ready);
endinterface

[sv/mhpq_out_if.sv]
// Result channel of the min-heap priority queue.
`timescale 1ns / 1ps

interface mhpq_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [mhpq_pkg::KEY_W-1:0] extracted_key;
  logic [1:0]                       status;
  logic signed [mhpq_pkg::KEY_W-1:0] min_key;
  logic                             min_valid;
  logic [mhpq_pkg::OCC_W-1:0]       occupancy;

  modport source (output valid, extracted_key, status, min_key, min_valid, occupancy,
                  input ready);
  modport sink   (input valid, extracted_key, status, min_key, min_valid, occupancy,
                  output ready);
endinterface

[sv/mhpq_ram.sv]
// Heap key store: one write port, two registered read ports.
`timescale 1ns / 1ps

module mhpq_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [mhpq_pkg::KEY_W-1:0] wdata,
  input  logic [AW-1:0]              raddr_a,
  input  logic [AW-1:0]              raddr_b,
  output logic [mhpq_pkg::KEY_W-1:0] rdata_a,
  output logic [mhpq_pkg::KEY_W-1:0] rdata_b
);

  logic [mhpq_pkg::KEY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

[sv/min_heap_priority_queue.sv]
// Accept to result beat: a full insert, or an extract leaving no entry, goes straight to S_RESP;
// an insert climbs one level per S_UP_RD/S_UP_CMP pair, stopping at the root or a parent no larger;
// an extract loads the last entry in S_EX_LAST, then descends by S_DN_RD/S_DN_CMP pairs,
// at most log2(DEPTH) levels. One command at a time: the sift walk over the key store and a
// stalled result beat set the rate; the worst walk at DEPTH 64 is an insert climbing six levels.
// A new command is taken while the previous result beat still waits; reset clears the count.
`timescale 1ns / 1ps

module min_heap_priority_queue #(
  parameter int DEPTH = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  mhpq_in_if.sink                         in_if,
  mhpq_out_if.source                      out_if,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mhpq_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [mhpq_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [mhpq_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > mhpq_pkg::CAP_W) ? CW : mhpq_pkg::CAP_W;
  localparam int KW = mhpq_pkg::KEY_W;

  // configuration
  logic [mhpq_pkg::CAP_W-1:0] cap_r;
  logic                       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite &&
                  (paddr[mhpq_pkg::CFG_ADDR_W-1:2] == mhpq_pkg::REG_CAPACITY);
  assign prdata = (paddr[mhpq_pkg::CFG_ADDR_W-1:2] == mhpq_pkg::REG_CAPACITY) ?
                  mhpq_pkg::CFG_DATA_W'(cap_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= mhpq_pkg::CAP_RESET;
    end else if (cfg_wr) begin
      cap_r <= pwdata[mhpq_pkg::CAP_W-1:0];
    end
  end

  // state
  mhpq_pkg::state_t    state_r, state_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [CW-1:0]       pos_r, pos_nxt;
  logic signed [KW-1:0] val_r, val_nxt;
  logic signed [KW-1:0] ext_r, ext_nxt;
  mhpq_pkg::status_t   status_r, status_nxt;
  logic signed [KW-1:0] root_r, root_nxt;

  // output register
  logic                 out_valid_r;
  logic signed [KW-1:0] o_ext_r, o_min_r;
  logic [1:0]           o_status_r;
  logic                 o_min_valid_r;
  logic [mhpq_pkg::OCC_W-1:0] o_occ_r;

  // memory port
  logic          we;
  logic [AW-1:0] waddr, raddr_a, raddr_b;
  logic [KW-1:0] wdata, rd_a, rd_b;

  mhpq_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  // decode
  logic          accept, is_insert, full, load;
  logic [CW-1:0] parent;
  logic [CW:0]   child_l, child_r, cnt_x;
  logic          up_less, dn_leaf, take_l, take_r;
  logic signed [KW-1:0] best_l;

  assign accept    = in_if.valid && in_if.ready;
  assign is_insert = (in_if.command == mhpq_pkg::CMD_INSERT);
  assign full      = (XW'(cnt_r) >= XW'(cap_r)) || (cnt_r == CW'(DEPTH));
  assign load      = (state_r == mhpq_pkg::S_RESP) && (!out_valid_r || out_if.ready);

  assign parent  = pos_r >> 1;
  assign child_l = {pos_r, 1'b0};
  assign child_r = {pos_r, 1'b1};
  assign cnt_x   = {1'b0, cnt_r};
  assign up_less = val_r < $signed(rd_a);
  assign dn_leaf = child_l > cnt_x;
  // left wins on a tie: right must be strictly smaller than the best so far
  assign take_l  = (child_l <= cnt_x) && ($signed(rd_a) < val_r);
  assign best_l  = take_l ? $signed(rd_a) : val_r;
  assign take_r  = (child_r <= cnt_x) && ($signed(rd_b) < best_l);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mhpq_pkg::S_IDLE: begin
        if (accept) begin
          if (is_insert) begin
            state_nxt = full ? mhpq_pkg::S_RESP : mhpq_pkg::S_UP_RD;
          end else if (cnt_r > CW'(1)) begin
            state_nxt = mhpq_pkg::S_EX_LAST;
          end else begin
            state_nxt = mhpq_pkg::S_RESP;
          end
        end
      end
      mhpq_pkg::S_UP_RD: begin
        state_nxt = (pos_r == CW'(1)) ? mhpq_pkg::S_RESP : mhpq_pkg::S_UP_CMP;
      end
      mhpq_pkg::S_UP_CMP: begin
        state_nxt = up_less ? mhpq_pkg::S_UP_RD : mhpq_pkg::S_RESP;
      end
      mhpq_pkg::S_EX_LAST: begin
        state_nxt = mhpq_pkg::S_DN_RD;
      end
      mhpq_pkg::S_DN_RD: begin
        state_nxt = dn_leaf ? mhpq_pkg::S_RESP : mhpq_pkg::S_DN_CMP;
      end
      mhpq_pkg::S_DN_CMP: begin
        state_nxt = (take_l || take_r) ? mhpq_pkg::S_DN_RD : mhpq_pkg::S_RESP;
      end
      mhpq_pkg::S_RESP: begin
        if (load) begin
          state_nxt = mhpq_pkg::S_IDLE;
        end
      end
      default: state_nxt = mhpq_pkg::S_IDLE;
    endcase
  end

  // FSM outputs: handshake and memory port
  always_comb begin
    in_if.ready = 1'b0;
    we          = 1'b0;
    waddr       = AW'(pos_r - CW'(1));
    wdata       = val_r;
    raddr_a     = AW'(cnt_r - CW'(1));
    raddr_b     = AW'(child_l);
    case (state_r)
      mhpq_pkg::S_IDLE: begin
        in_if.ready = 1'b1;  // read port A fetches the last entry for an extract
      end
      mhpq_pkg::S_UP_RD: begin
        raddr_a = AW'(parent - CW'(1));
        we      = (pos_r == CW'(1));
      end
      mhpq_pkg::S_UP_CMP: begin
        we = 1'b1;
        if (up_less) begin
          wdata = rd_a;  // parent moves down into the hole
        end
      end
      mhpq_pkg::S_DN_RD: begin
        raddr_a = AW'(child_l - (CW+1)'(1));
        we      = dn_leaf;
      end
      mhpq_pkg::S_DN_CMP: begin
        we = 1'b1;
        if (take_r) begin
          wdata = rd_b;
        end else if (take_l) begin
          wdata = rd_a;
        end
      end
      default: begin
      end
    endcase
  end

  // datapath
  always_comb begin
    cnt_nxt    = cnt_r;
    pos_nxt    = pos_r;
    val_nxt    = val_r;
    ext_nxt    = ext_r;
    status_nxt = status_r;
    root_nxt   = (we && waddr == '0) ? $signed(wdata) : root_r;
    case (state_r)
      mhpq_pkg::S_IDLE: begin
        if (accept) begin
          ext_nxt    = '0;
          status_nxt = mhpq_pkg::ST_OK;
          if (is_insert) begin
            if (full) begin
              status_nxt = mhpq_pkg::ST_FULL;
            end else begin
              cnt_nxt = cnt_r + CW'(1);
              pos_nxt = cnt_r + CW'(1);
              val_nxt = in_if.key_in;
            end
          end else if (cnt_r == '0) begin
            status_nxt = mhpq_pkg::ST_EMPTY;
          end else begin
            ext_nxt = root_r;
            cnt_nxt = cnt_r - CW'(1);
          end
        end
      end
      mhpq_pkg::S_UP_CMP: begin
        if (up_less) begin
          pos_nxt = parent;
        end
      end
      mhpq_pkg::S_EX_LAST: begin
        val_nxt = $signed(rd_a);
        pos_nxt = CW'(1);
      end
      mhpq_pkg::S_DN_CMP: begin
        if (take_r) begin
          pos_nxt = CW'(child_r);
        end else if (take_l) begin
          pos_nxt = CW'(child_l);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mhpq_pkg::S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    val_r    <= val_nxt;
    ext_r    <= ext_nxt;
    status_r <= status_nxt;
    root_r   <= root_nxt;
  end

  // result beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      o_ext_r       <= ext_r;
      o_status_r    <= status_r;
      o_min_r       <= (cnt_r != '0) ? root_r : '0;
      o_min_valid_r <= (cnt_r != '0);
      o_occ_r       <= mhpq_pkg::OCC_W'(cnt_r);
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.extracted_key = o_ext_r;
  assign out_if.status        = o_status_r;
  assign out_if.min_key       = o_min_r;
  assign out_if.min_valid     = o_min_valid_r;
  assign out_if.occupancy     = o_occ_r;

endmodule

[sv/mhpq_checker.sv]
// Port-level checks for the min-heap priority queue, bound to the top level.
`timescale 1ns / 1ps

module mhpq_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [mhpq_pkg::KEY_W-1:0]       out_extracted_key,
  input logic [1:0]                       out_status,
  input logic [mhpq_pkg::KEY_W-1:0]       out_min_key,
  input logic                             out_min_valid,
  input logic [mhpq_pkg::OCC_W-1:0]       out_occupancy
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_extracted_key) &&
    $stable(out_status) && $stable(out_min_key) && $stable(out_occupancy))
    else $error("result beat changed while stalled");

  // one command in flight: no back-to-back accept
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("command taken while another is in flight");

  a_min_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_min_valid == (out_occupancy != '0)) &&
                  (out_min_valid || out_min_key == '0))
    else $error("min_valid, min_key and occupancy disagree");

  a_refused: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == mhpq_pkg::ST_FULL || out_status == mhpq_pkg::ST_EMPTY)
    |-> out_extracted_key == '0)
    else $error("refused command returned a key");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == mhpq_pkg::ST_EMPTY |-> out_occupancy == '0)
    else $error("empty status with entries held");

endmodule

bind min_heap_priority_queue mhpq_checker u_mhpq_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_if.valid),
  .in_ready          (in_if.ready),
  .out_valid         (out_if.valid),
  .out_ready         (out_if.ready),
  .out_extracted_key (out_if.extracted_key),
  .out_status        (out_if.status),
  .out_min_key       (out_if.min_key),
  .out_min_valid     (out_if.min_valid),
  .out_occupancy     (out_if.occupancy)
);

[tb/mhpq_heap_checker.sv]
// Result checker for the min-heap priority queue: shadow heap, expected-result queue, compare.
`timescale 1ns / 1ps

module mhpq_heap_checker #(
  parameter int DEPTH = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  mhpq_in_if                              in_mon,
  mhpq_out_if                             out_mon,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic                            pready,
  input  logic [mhpq_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [mhpq_pkg::CFG_DATA_W-1:0] pwdata,
  output int                              results_pending,
  output int                              fail_count
);

  typedef struct packed {
    logic signed [mhpq_pkg::KEY_W-1:0] extracted_key;
    mhpq_pkg::status_t                 status;
    logic signed [mhpq_pkg::KEY_W-1:0] min_key;
    logic                              min_valid;
    logic [mhpq_pkg::OCC_W-1:0]        occupancy;
  } heap_result_t;

  // shadow copy of the queue, one-based like the block's heap positions
  logic signed [mhpq_pkg::KEY_W-1:0] shadow_keys [1:DEPTH];
  int unsigned                       shadow_count;
  logic [mhpq_pkg::CAP_W-1:0]        shadow_capacity;
  heap_result_t                      expected_results [$];

  function automatic heap_result_t apply_heap_command(
      input mhpq_pkg::cmd_t cmd, input logic signed [mhpq_pkg::KEY_W-1:0] key);
    heap_result_t                      res;
    int unsigned                       cap;
    int unsigned                       pos;
    int unsigned                       best;
    int unsigned                       kid;
    logic signed [mhpq_pkg::KEY_W-1:0] tmp;
    bit                                descending;
    res = '0;
    res.status = mhpq_pkg::ST_OK;
    cap = (shadow_capacity > DEPTH) ? DEPTH : shadow_capacity;
    if (cmd == mhpq_pkg::CMD_INSERT) begin
      if (shadow_count >= cap) begin
        res.status = mhpq_pkg::ST_FULL;
      end else begin
        shadow_count++;
        pos = shadow_count;
        shadow_keys[pos] = key;
        while (pos > 1 && shadow_keys[pos] < shadow_keys[pos / 2]) begin
          tmp = shadow_keys[pos];
          shadow_keys[pos] = shadow_keys[pos / 2];
          shadow_keys[pos / 2] = tmp;
          pos = pos / 2;
        end
      end
    end else if (shadow_count == 0) begin
      res.status = mhpq_pkg::ST_EMPTY;
    end else begin
      res.extracted_key = shadow_keys[1];
      shadow_keys[1] = shadow_keys[shadow_count];
      shadow_count--;
      pos = 1;
      descending = 1'b1;
      // ties go to the left child
      while (descending) begin
        best = pos;
        kid = 2 * pos;
        if (kid <= shadow_count && shadow_keys[kid] < shadow_keys[best]) best = kid;
        if (kid + 1 <= shadow_count && shadow_keys[kid + 1] < shadow_keys[best]) best = kid + 1;
        if (best == pos) begin
          descending = 1'b0;
        end else begin
          tmp = shadow_keys[pos];
          shadow_keys[pos] = shadow_keys[best];
          shadow_keys[best] = tmp;
          pos = best;
        end
      end
    end
    res.min_valid = (shadow_count > 0);
    res.min_key   = (shadow_count > 0) ? shadow_keys[1] : '0;
    res.occupancy = shadow_count[mhpq_pkg::OCC_W-1:0];
    return res;
  endfunction

  task automatic check_field(input string name,
                             input logic signed [mhpq_pkg::KEY_W:0] want,
                             input logic signed [mhpq_pkg::KEY_W:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    heap_result_t want;
    if (!rst_n) begin
      shadow_count = 0;
      shadow_capacity = mhpq_pkg::CAP_RESET;
      expected_results.delete();
    end else begin
      // result side first: a beat leaving now belongs to an older command
      if (out_mon.valid && out_mon.ready) begin
        if (expected_results.size() == 0) begin
          $error("result beat with no command outstanding");
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("extracted_key", want.extracted_key, out_mon.extracted_key);
          check_field("status", want.status, out_mon.status);
          check_field("min_key", want.min_key, out_mon.min_key);
          check_field("min_valid", want.min_valid, out_mon.min_valid);
          check_field("occupancy", want.occupancy, out_mon.occupancy);
        end
      end
      if (psel && penable && pwrite && pready &&
          paddr[mhpq_pkg::CFG_ADDR_W-1:2] == mhpq_pkg::REG_CAPACITY)
        shadow_capacity = pwdata[mhpq_pkg::CAP_W-1:0];
      if (in_mon.valid && in_mon.ready)
        expected_results.push_back(
            apply_heap_command(mhpq_pkg::cmd_t'(in_mon.command), in_mon.key_in));
    end
    results_pending = expected_results.size();
  end

endmodule

[tb/tb_min_heap_priority_queue.sv]
// Testbench top of the min-heap priority queue: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_min_heap_priority_queue;

  localparam logic signed [mhpq_pkg::KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [mhpq_pkg::KEY_W-1:0] KEY_MIN = 32'sh8000_0000;

  logic                            clk;
  logic                            rst_n;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [mhpq_pkg::CFG_ADDR_W-1:0] paddr;
  logic [mhpq_pkg::CFG_DATA_W-1:0] pwdata;
  logic [mhpq_pkg::CFG_DATA_W-1:0] prdata;
  logic                            pready;
  int                              results_pending;
  int                              fail_count;
  bit                              idle_on;

  mhpq_in_if  cmd_ch ();
  mhpq_out_if res_ch ();

  min_heap_priority_queue #(.DEPTH(64)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (cmd_ch),
    .out_if (res_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  mhpq_heap_checker #(.DEPTH(64)) heap_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (cmd_ch),
    .out_mon        (res_ch),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .results_pending(results_pending),
    .fail_count     (fail_count)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin
    #2ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // result side backpressure
  initial begin
    int hold;
    hold = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold == 0 && idle_on && $urandom_range(0, 7) == 0) hold = $urandom_range(1, 11);
      if (hold > 0) begin
        res_ch.ready <= 1'b0;
        hold--;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  function automatic logic signed [mhpq_pkg::KEY_W-1:0] pick_key();
    case ($urandom_range(0, 3))
      0: return $signed($urandom_range(0, 8)) - 4;
      1: begin
        case ($urandom_range(0, 3))
          0: return KEY_MAX;
          1: return KEY_MIN;
          2: return '0;
          default: return -1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic send_command(input mhpq_pkg::cmd_t cmd,
                              input logic signed [mhpq_pkg::KEY_W-1:0] key);
    int gap;
    gap = (idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 11) : 0;
    repeat (gap) begin
      @(negedge clk);
      cmd_ch.valid <= 1'b0;
    end
    @(negedge clk);
    cmd_ch.valid   <= 1'b1;
    cmd_ch.command <= cmd;
    cmd_ch.key_in  <= key;
    do @(posedge clk); while (!cmd_ch.ready);
  endtask

  // drop valid and let every outstanding result beat drain
  task automatic drain_results();
    @(negedge clk);
    cmd_ch.valid <= 1'b0;
    while (results_pending != 0) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [mhpq_pkg::CAP_W-1:0] cap);
    drain_results();
    repeat (4) @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {mhpq_pkg::REG_CAPACITY, 2'b00};
    pwdata  <= mhpq_pkg::CFG_DATA_W'(cap);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic random_traffic(input int count, input int insert_pct);
    repeat (count) begin
      if (idle_on && $urandom_range(0, 29) == 0) drain_results();
      send_command(($urandom_range(1, 100) <= insert_pct) ?
                   mhpq_pkg::CMD_INSERT : mhpq_pkg::CMD_EXTRACT, pick_key());
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    idle_on        = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    cmd_ch.valid   = 1'b0;
    cmd_ch.command = mhpq_pkg::CMD_INSERT;
    cmd_ch.key_in  = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, duplicates, empty heap, full and shrunk capacity
    idle_on = 1'b1;
    send_command(mhpq_pkg::CMD_EXTRACT, 32'sd9);
    send_command(mhpq_pkg::CMD_INSERT, KEY_MAX);
    send_command(mhpq_pkg::CMD_INSERT, KEY_MIN);
    send_command(mhpq_pkg::CMD_INSERT, 32'sd0);
    send_command(mhpq_pkg::CMD_INSERT, -32'sd1);
    send_command(mhpq_pkg::CMD_INSERT, 32'sd5);
    send_command(mhpq_pkg::CMD_INSERT, -32'sd1);
    send_command(mhpq_pkg::CMD_INSERT, 32'sd1);
    repeat (7) send_command(mhpq_pkg::CMD_EXTRACT, KEY_MAX);
    send_command(mhpq_pkg::CMD_EXTRACT, KEY_MIN);

    write_capacity(7'd3);
    send_command(mhpq_pkg::CMD_INSERT, 32'sd4);
    send_command(mhpq_pkg::CMD_INSERT, 32'sd2);
    send_command(mhpq_pkg::CMD_INSERT, 32'sd3);
    send_command(mhpq_pkg::CMD_INSERT, KEY_MIN);
    // occupancy now above the new limit
    write_capacity(7'd1);
    send_command(mhpq_pkg::CMD_INSERT, 32'sd1);
    repeat (4) send_command(mhpq_pkg::CMD_EXTRACT, '0);

    write_capacity(7'd0);
    send_command(mhpq_pkg::CMD_INSERT, 32'sd7);
    send_command(mhpq_pkg::CMD_EXTRACT, 32'sd7);

    // random: above DEPTH saturates, insert-heavy so the store fills
    write_capacity(7'd127);
    random_traffic(110, 75);
    write_capacity(7'd64);
    random_traffic(80, 50);
    write_capacity(7'd5);
    random_traffic(60, 55);
    write_capacity(7'd63);
    random_traffic(80, 45);

    // last stretch without any idling
    write_capacity(7'd64);
    idle_on = 1'b0;
    random_traffic(100, 50);

    drain_results();
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[files.f]
sv/mhpq_pkg.sv
sv/mhpq_in_if.sv
sv/mhpq_out_if.sv
sv/mhpq_ram.sv
sv/min_heap_priority_queue.sv
sv/mhpq_checker.sv
tb/mhpq_heap_checker.sv
tb/tb_min_heap_priority_queue.sv
